// File: hw/rtl/pwft_pkg.sv
package pwft_pkg;

  localparam int MAX_BYTES_DEF = 64;
  localparam int TICK_W        = 12;
  localparam int CFG_ADDR_W    = 3;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START     = 3'd1,
    PH_START_GAP = 3'd2,
    PH_BIT_HIGH  = 3'd3,
    PH_BIT_GAP   = 3'd4,
    PH_END_LOW   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_START_HIGH = 3'd1,
    REG_BIT0_HIGH  = 3'd2,
    REG_BIT1_HIGH  = 3'd3,
    REG_GAP_LOW    = 3'd4,
    REG_END_LOW    = 3'd5
  } cfg_reg_t;

  localparam logic [TICK_W-1:0] START_HIGH_RST = 12'd150;
  localparam logic [TICK_W-1:0] BIT0_HIGH_RST  = 12'd40;
  localparam logic [TICK_W-1:0] BIT1_HIGH_RST  = 12'd70;
  localparam logic [TICK_W-1:0] GAP_LOW_RST    = 12'd30;
  localparam logic [TICK_W-1:0] END_LOW_RST    = 12'd100;

  // a zero duration lasts one tick
  function automatic logic [TICK_W-1:0] dur(input logic [TICK_W-1:0] v);
    dur = (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// File: hw/rtl/pwft_in_if.sv
interface pwft_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, mode, byte_value, last_byte, input ready);
  modport sink   (input valid, mode, byte_value, last_byte, output ready);
endinterface

// File: hw/rtl/pwft_out_if.sv
interface pwft_out_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic [1:0] status;
  logic       frame_done;

  modport source (output valid, line_level, status, frame_done, input ready);
  modport sink   (input valid, line_level, status, frame_done, output ready);
endinterface

// File: hw/rtl/pwft_cfg_if.sv
interface pwft_cfg_if
  import pwft_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [TICK_W-1:0]     wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// File: hw/rtl/pulse_width_frame_transmitter.sv
// result: registered in the cycle after its request is accepted
// throughput: one request per cycle, byte or tick, while results are taken;
//   a result left waiting holds off the next request
// the frame buffer is a one-port-write, one-port-read memory with registered read
// reset (synchronous, rst_n low): disabled, idle, buffer empty, durations back
//   to 150/40/70/30/100 ticks; buffer contents stay undefined until written
module pulse_width_frame_transmitter
  import pwft_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pwft_in_if.sink     in_if,
  pwft_out_if.source  out_if,
  pwft_cfg_if.sink    cfg_if
);

  // byte counter must hold MAX_BYTES itself; memory address covers the depth
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  // configuration registers
  logic              enable_r,     enable_nxt;
  logic [TICK_W-1:0] start_high_r, start_high_nxt;
  logic [TICK_W-1:0] bit0_high_r,  bit0_high_nxt;
  logic [TICK_W-1:0] bit1_high_r,  bit1_high_nxt;
  logic [TICK_W-1:0] gap_low_r,    gap_low_nxt;
  logic [TICK_W-1:0] end_low_r,    end_low_nxt;

  // frame sequencer state
  phase_t            phase_r,      phase_nxt;
  logic [CW-1:0]     byte_count_r, byte_count_nxt;
  logic [CW-1:0]     send_index_r, send_index_nxt;
  logic [2:0]        bit_index_r,  bit_index_nxt;
  logic [TICK_W-1:0] tick_left_r,  tick_left_nxt;
  logic              overflow_r,   overflow_nxt;

  // byte being sent and prefetched successor
  logic [7:0]        cur_byte_r,   cur_byte_nxt;
  logic [7:0]        next_byte_r;

  // result register
  logic              out_valid_r,  out_valid_nxt;
  logic              line_r;
  status_t           status_r;
  logic              done_r;
  logic              res_line;
  status_t           res_status;
  logic              res_done;

  // frame buffer
  logic [7:0]        mem_r [MAX_BYTES];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CW:0]       rd_idx;
  logic              rd_en;

  logic              in_fire;
  logic              cfg_fire;
  logic              is_tick;
  logic              level_now;
  logic [TICK_W-1:0] tick_dec;
  logic              tick_zero;
  logic              bit_wrap;
  logic [CW-1:0]     send_inc;
  logic [2:0]        bit_inc;
  logic [7:0]        load_byte;
  logic              load_val;

  // request can enter whenever the result slot is free or being drained
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;
  assign is_tick      = (in_if.mode == MODE_TICK);

  assign level_now = (phase_r == PH_START) || (phase_r == PH_BIT_HIGH);
  assign tick_dec  = (tick_left_r != '0) ? tick_left_r - TICK_W'(1) : tick_left_r;
  assign tick_zero = (tick_dec == '0);

  // bit stepping: wrap to the next byte after bit 7
  assign bit_wrap  = (bit_index_r == 3'd7);
  assign bit_inc   = bit_index_r + 3'd1;
  assign send_inc  = send_index_r + CW'(bit_wrap);
  assign load_byte = bit_wrap ? next_byte_r : cur_byte_r;
  assign load_val  = load_byte[bit_inc];

  // buffer write happens only for an accepted byte while idle and not full
  assign wr_en   = in_fire && enable_r && !is_tick && (phase_r == PH_IDLE)
                   && !overflow_r && (byte_count_r < CW'(MAX_BYTES));
  assign wr_addr = byte_count_r[AW-1:0];

  // prefetch the byte after the one being sent
  assign rd_idx = {1'b0, send_index_r} + (CW+1)'(1);
  assign rd_en  = (rd_idx < (CW+1)'(MAX_BYTES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= in_if.byte_value;
    end
    if (rd_en) begin
      next_byte_r <= mem_r[rd_idx[AW-1:0]];
    end
  end

  // result of the accepted request
  always_comb begin
    res_line   = 1'b0;
    res_status = ST_OK;
    res_done   = 1'b0;
    if (!enable_r) begin
      res_status = ST_DISABLED;
    end else if (!is_tick) begin
      res_line = level_now;
      if (phase_r != PH_IDLE) begin
        res_status = ST_BUSY;
      end else if (overflow_r || byte_count_r >= CW'(MAX_BYTES)) begin
        res_status = ST_OVERFLOW;
      end
    end else if (phase_r != PH_IDLE) begin
      res_line = level_now;
      res_done = (phase_r == PH_END_LOW) && tick_zero;
    end
  end

  // next state
  always_comb begin
    enable_nxt     = enable_r;
    start_high_nxt = start_high_r;
    bit0_high_nxt  = bit0_high_r;
    bit1_high_nxt  = bit1_high_r;
    gap_low_nxt    = gap_low_r;
    end_low_nxt    = end_low_r;
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    send_index_nxt = send_index_r;
    bit_index_nxt  = bit_index_r;
    tick_left_nxt  = tick_left_r;
    overflow_nxt   = overflow_r;
    cur_byte_nxt   = cur_byte_r;

    if (in_fire && enable_r) begin
      if (!is_tick) begin
        if (phase_r == PH_IDLE) begin
          if (overflow_r || byte_count_r >= CW'(MAX_BYTES)) begin
            // drop the rest of an oversized frame, flush on its last byte
            overflow_nxt = 1'b1;
            if (in_if.last_byte) begin
              byte_count_nxt = '0;
              overflow_nxt   = 1'b0;
            end
          end else begin
            byte_count_nxt = byte_count_r + CW'(1);
            // first byte is forwarded straight into the send register
            if (byte_count_r == '0) begin
              cur_byte_nxt = in_if.byte_value;
            end
            if (in_if.last_byte) begin
              phase_nxt      = PH_START;
              tick_left_nxt  = dur(start_high_r);
              send_index_nxt = '0;
              bit_index_nxt  = '0;
            end
          end
        end
      end else if (phase_r != PH_IDLE) begin
        tick_left_nxt = tick_dec;
        if (tick_zero) begin
          unique case (phase_r)
            PH_START: begin
              phase_nxt     = PH_START_GAP;
              tick_left_nxt = dur(gap_low_r);
            end
            PH_START_GAP: begin
              phase_nxt     = PH_BIT_HIGH;
              tick_left_nxt = dur(cur_byte_r[bit_index_r] ? bit1_high_r : bit0_high_r);
            end
            PH_BIT_HIGH: begin
              phase_nxt     = PH_BIT_GAP;
              tick_left_nxt = dur(gap_low_r);
            end
            PH_BIT_GAP: begin
              bit_index_nxt  = bit_inc;
              send_index_nxt = send_inc;
              if (bit_wrap) begin
                cur_byte_nxt = next_byte_r;
              end
              if (send_inc >= byte_count_r) begin
                phase_nxt     = PH_END_LOW;
                tick_left_nxt = dur(end_low_r);
              end else begin
                phase_nxt     = PH_BIT_HIGH;
                tick_left_nxt = dur(load_val ? bit1_high_r : bit0_high_r);
              end
            end
            default: begin
              // end low time complete: frame finished
              phase_nxt      = PH_IDLE;
              byte_count_nxt = '0;
              send_index_nxt = '0;
              bit_index_nxt  = '0;
              tick_left_nxt  = '0;
              overflow_nxt   = 1'b0;
            end
          endcase
        end
      end
    end

    if (cfg_fire) begin
      unique case (cfg_if.addr)
        REG_ENABLE: begin
          enable_nxt = cfg_if.wdata[0];
          // disabling aborts the frame and empties the buffer
          if (!cfg_if.wdata[0]) begin
            phase_nxt      = PH_IDLE;
            byte_count_nxt = '0;
            send_index_nxt = '0;
            bit_index_nxt  = '0;
            tick_left_nxt  = '0;
            overflow_nxt   = 1'b0;
          end
        end
        REG_START_HIGH: start_high_nxt = cfg_if.wdata;
        REG_BIT0_HIGH:  bit0_high_nxt  = cfg_if.wdata;
        REG_BIT1_HIGH:  bit1_high_nxt  = cfg_if.wdata;
        REG_GAP_LOW:    gap_low_nxt    = cfg_if.wdata;
        REG_END_LOW:    end_low_nxt    = cfg_if.wdata;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      start_high_r <= START_HIGH_RST;
      bit0_high_r  <= BIT0_HIGH_RST;
      bit1_high_r  <= BIT1_HIGH_RST;
      gap_low_r    <= GAP_LOW_RST;
      end_low_r    <= END_LOW_RST;
      phase_r      <= PH_IDLE;
      byte_count_r <= '0;
      send_index_r <= '0;
      bit_index_r  <= '0;
      tick_left_r  <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      enable_r     <= enable_nxt;
      start_high_r <= start_high_nxt;
      bit0_high_r  <= bit0_high_nxt;
      bit1_high_r  <= bit1_high_nxt;
      gap_low_r    <= gap_low_nxt;
      end_low_r    <= end_low_nxt;
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      send_index_r <= send_index_nxt;
      bit_index_r  <= bit_index_nxt;
      tick_left_r  <= tick_left_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_byte_r <= cur_byte_nxt;
    if (in_fire) begin
      line_r   <= res_line;
      status_r <= res_status;
      done_r   <= res_done;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.line_level = line_r;
  assign out_if.status     = status_r;
  assign out_if.frame_done = done_r;

  // an idle sequencer holds no countdown and no send position
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_left_r == '0 && send_index_r == '0 && bit_index_r == '0))
    else $error("idle with stale sequencer state");

  // while bits are still going out the send position stays inside the frame
  a_send_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE && phase_r != PH_END_LOW) |-> (send_index_r < byte_count_r))
    else $error("send position beyond buffered bytes");

  // disabled transmitter never has a frame in flight
  a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !enable_r |-> (phase_r == PH_IDLE && byte_count_r == '0))
    else $error("frame state while disabled");

  // a byte offered during transmission is reported busy
  a_busy_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && enable_r && !is_tick && phase_r != PH_IDLE && !cfg_fire)
    |=> (out_if.valid && out_if.status == ST_BUSY))
    else $error("byte during transmission not flagged busy");

  // frame completion comes with a low line and ok status
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.frame_done) |-> (!out_if.line_level && out_if.status == ST_OK))
    else $error("frame done with bad level or status");

endmodule
